@@ rtl/bpc_pkg.sv @@
// ----------------------------------------------------------------------------
// bpc_pkg
// Shared types, widths and codes for the button press classifier.
// ----------------------------------------------------------------------------
package bpc_pkg;

    // field widths
    localparam int TimeW  = 32;
    localparam int CfgW   = 16;
    localparam int CountW = 2;
    localparam int EventW = 3;
    localparam int CfgAddrW = 2;

    // packed stream widths
    localparam int InDataW  = 40;  // level, now_ms, zero fill to whole bytes
    localparam int OutDataW = 8;   // event_res, zero fill

    // item kinds carried on tuser
    localparam logic OpSample = 1'b0;
    localparam logic OpClear  = 1'b1;

    // latched event codes
    localparam logic [EventW-1:0] EvIdle   = 3'd0;
    localparam logic [EventW-1:0] EvPress  = 3'd1;
    localparam logic [EventW-1:0] EvDouble = 3'd2;
    localparam logic [EventW-1:0] EvTriple = 3'd3;
    localparam logic [EventW-1:0] EvHeld   = 3'd4;
    localparam logic [EventW-1:0] EvLong   = 3'd5;

    // register indexes
    localparam logic [CfgAddrW-1:0] RegDebounce  = 2'd0;
    localparam logic [CfgAddrW-1:0] RegMulti     = 2'd1;
    localparam logic [CfgAddrW-1:0] RegHoldShort = 2'd2;
    localparam logic [CfgAddrW-1:0] RegHoldLong  = 2'd3;

    // register reset values
    localparam logic [CfgW-1:0] DebounceRst  = 16'd50;
    localparam logic [CfgW-1:0] MultiRst     = 16'd300;
    localparam logic [CfgW-1:0] HoldShortRst = 16'd2000;
    localparam logic [CfgW-1:0] HoldLongRst  = 16'd3000;

    // configuration bundle
    typedef struct packed {
        logic [CfgW-1:0] debounce_ms;
        logic [CfgW-1:0] multi_press_ms;
        logic [CfgW-1:0] hold_short_ms;
        logic [CfgW-1:0] hold_long_ms;
    } t_cfg;

    // one registered input item
    typedef struct packed {
        logic              op;
        logic              level;
        logic [TimeW-1:0]  now_ms;
    } t_item;

endpackage

@@ rtl/bpc_cfg.sv @@
// ----------------------------------------------------------------------------
// bpc_cfg
// Configuration register file, written through a plain write port.
// ----------------------------------------------------------------------------
module bpc_cfg (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [bpc_pkg::CfgAddrW-1:0] i_cfg_addr,
    input  logic [bpc_pkg::CfgW-1:0]     i_cfg_wdata,
    output bpc_pkg::t_cfg                o_cfg
);

    bpc_pkg::t_cfg r_cfg;

    // write the addressed register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.debounce_ms    <= bpc_pkg::DebounceRst;
            r_cfg.multi_press_ms <= bpc_pkg::MultiRst;
            r_cfg.hold_short_ms  <= bpc_pkg::HoldShortRst;
            r_cfg.hold_long_ms   <= bpc_pkg::HoldLongRst;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                bpc_pkg::RegDebounce:  r_cfg.debounce_ms    <= i_cfg_wdata;
                bpc_pkg::RegMulti:     r_cfg.multi_press_ms <= i_cfg_wdata;
                bpc_pkg::RegHoldShort: r_cfg.hold_short_ms  <= i_cfg_wdata;
                bpc_pkg::RegHoldLong:  r_cfg.hold_long_ms   <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

@@ rtl/bpc_in_reg.sv @@
// ----------------------------------------------------------------------------
// bpc_in_reg
// Input register: unpacks and holds one item until the core takes it.
// ----------------------------------------------------------------------------
module bpc_in_reg (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_s_tvalid,
    output logic                        o_s_tready,
    input  logic [bpc_pkg::InDataW-1:0] i_s_tdata,
    input  logic                        i_s_tuser,
    input  logic                        i_take,
    output logic                        o_valid,
    output bpc_pkg::t_item              o_item
);

    logic           r_valid;
    bpc_pkg::t_item r_item;

    // accept when empty or when the held item leaves this cycle
    assign o_s_tready = !r_valid || i_take;

    // track occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_valid <= i_s_tvalid;
        end
    end

    // capture payload
    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_item.op     <= i_s_tuser;
            r_item.level  <= i_s_tdata[0];
            r_item.now_ms <= i_s_tdata[bpc_pkg::TimeW:1];
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

@@ rtl/bpc_core.sv @@
// ----------------------------------------------------------------------------
// bpc_core
// Edge detection, press classification and event latch, with result register.
// ----------------------------------------------------------------------------
module bpc_core (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  bpc_pkg::t_cfg                i_cfg,
    input  logic                         i_valid,
    input  bpc_pkg::t_item               i_item,
    output logic                         o_take,
    output logic                         o_m_tvalid,
    input  logic                         i_m_tready,
    output logic [bpc_pkg::OutDataW-1:0] o_m_tdata
);

    logic                         r_prev_level;
    logic [bpc_pkg::TimeW-1:0]    r_press_start;
    logic [bpc_pkg::TimeW-1:0]    r_last_release;
    logic [bpc_pkg::CountW-1:0]   r_count;
    logic [bpc_pkg::EventW-1:0]   r_event;
    logic                         r_out_valid;

    logic                         n_prev_level;
    logic [bpc_pkg::TimeW-1:0]    n_press_start;
    logic [bpc_pkg::TimeW-1:0]    n_last_release;
    logic [bpc_pkg::CountW-1:0]   n_count;
    logic [bpc_pkg::EventW-1:0]   n_event;

    logic [bpc_pkg::TimeW-1:0]    press_len;
    logic [bpc_pkg::TimeW-1:0]    quiet_len;
    logic                         rise;
    logic                         fall;
    logic                         counted;
    logic                         is_short;
    logic                         is_held;
    logic                         is_long;
    logic                         seq_end;
    logic                         advance;

    // move the item on when the result register is free or being drained
    assign advance = !r_out_valid || i_m_tready;
    assign o_take  = i_valid && advance;

    // press and quiet lengths, modulo 2^32
    assign press_len = i_item.now_ms - r_press_start;
    assign quiet_len = i_item.now_ms - r_last_release;

    assign rise    = i_item.level && !r_prev_level;
    assign fall    = !i_item.level && r_prev_level;
    assign counted = fall && (press_len >= {16'd0, i_cfg.debounce_ms});
    assign is_short = counted && (press_len < {16'd0, i_cfg.hold_short_ms});
    assign is_held  = counted && !is_short && (press_len < {16'd0, i_cfg.hold_long_ms});
    assign is_long  = counted && !is_short && !is_held;

    // a short press this item resets the quiet gap to zero, so no sequence end
    assign seq_end = !counted && (r_count != '0)
                     && (quiet_len > {16'd0, i_cfg.multi_press_ms});

    // next state for one item
    always_comb begin
        n_prev_level   = r_prev_level;
        n_press_start  = r_press_start;
        n_last_release = r_last_release;
        n_count        = r_count;
        n_event        = r_event;
        if (i_item.op == bpc_pkg::OpClear) begin
            n_event = bpc_pkg::EvIdle;
        end else begin
            n_prev_level = i_item.level;
            if (rise) begin
                n_press_start = i_item.now_ms;
            end
            if (is_short) begin
                n_last_release = i_item.now_ms;
                if (r_count != 2'd3) begin
                    n_count = r_count + 2'd1;
                end
            end
            if (is_held) begin
                n_event = bpc_pkg::EvHeld;
                n_count = '0;
            end
            if (is_long) begin
                n_event = bpc_pkg::EvLong;
                n_count = '0;
            end
            if (seq_end) begin
                // count of one, two or three maps onto press, double, triple
                n_event = {1'b0, r_count};
                n_count = '0;
            end
        end
    end

    // state and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_level   <= 1'b0;
            r_press_start  <= '0;
            r_last_release <= '0;
            r_count        <= '0;
            r_event        <= bpc_pkg::EvIdle;
            r_out_valid    <= 1'b0;
        end else begin
            if (advance) begin
                r_out_valid <= i_valid;
            end
            if (o_take) begin
                r_prev_level   <= n_prev_level;
                r_press_start  <= n_press_start;
                r_last_release <= n_last_release;
                r_count        <= n_count;
                r_event        <= n_event;
            end
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {{(bpc_pkg::OutDataW-bpc_pkg::EventW){1'b0}}, r_event};

endmodule

@@ rtl/button_press_classifier_top.sv @@
// ----------------------------------------------------------------------------
// button_press_classifier_top
// Classifies button presses into press, double, triple, held and long held.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream: one item per sample. tuser is the kind (0 sample the level,
//   1 clear the latched event); tdata carries the level and the ms tick.
//   Master stream: one result per item, the latched event code in tdata.
//   Configuration: four 16-bit registers (debounce, multi-press gap, held and
//   long-held thresholds) written through i_cfg_we/i_cfg_addr/i_cfg_wdata,
//   only while no item is in flight.
//   Path: an accepted item sits in the input register while the classify logic
//   works on it, and the result register loads when the core takes the item.
//   Throughput: one item per cycle while the receiver takes each result; the
//   state update of the classify stage completes in the cycle the item is
//   taken, so items follow back to back.
//   Reset (i_rst_n low, synchronous) empties both stages, clears the press
//   state and count, sets the latched event to idle and loads the register
//   defaults (50, 300, 2000, 3000 ms).
//   A stalled receiver holds the result; the input register still takes one
//   more item, then o_s_tready drops until the result drains.
// ----------------------------------------------------------------------------
module button_press_classifier_top (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // slave stream
    input  logic                         i_s_tvalid,
    output logic                         o_s_tready,
    input  logic [bpc_pkg::InDataW-1:0]  i_s_tdata,   // [0] level, [32:1] now_ms, rest zero
    input  logic                         i_s_tuser,   // [0] op
    // master stream
    output logic                         o_m_tvalid,
    input  logic                         i_m_tready,
    output logic [bpc_pkg::OutDataW-1:0] o_m_tdata,   // [2:0] event_res, rest zero
    // configuration write port
    input  logic                         i_cfg_we,
    input  logic [bpc_pkg::CfgAddrW-1:0] i_cfg_addr,
    input  logic [bpc_pkg::CfgW-1:0]     i_cfg_wdata
);

    bpc_pkg::t_cfg  cfg;
    bpc_pkg::t_item item;
    logic           item_valid;
    logic           take;

    // configuration registers
    bpc_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    // input register
    bpc_in_reg u_in_reg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .i_take     (take),
        .o_valid    (item_valid),
        .o_item     (item)
    );

    // classifier and result register
    bpc_core u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (cfg),
        .i_valid    (item_valid),
        .i_item     (item),
        .o_take     (take),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

endmodule
